// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_END   = 1'b1;

  localparam logic [31:0] HEAP_START_RESET = 32'h0100_0000;
  localparam logic [31:0] HEAP_END_RESET   = 32'h1000_0000;
  localparam logic [31:0] HDR_BYTES        = 32'd16;
  localparam logic [32:0] ROUND_ADD        = 33'd15;
  localparam logic [32:0] ROUND_MASK       = ~33'd15;

  typedef enum logic [1:0] {
    OP_NOP     = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_REALLOC = 2'd3
  } op_t;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [31:0] req;
    logic [31:0] payload;
    logic [31:0] hdr;
    logic [32:0] sz;
    logic [33:0] need;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_bump_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_bump_allocator
// First-fit heap allocator with a LIFO free list and bump fallback.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ----------------------------------------
//   in        in_valid / in_stall    cmd, request_size, payload_addr
//   out       out_valid / out_stall  result_addr, status, copy_len
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is decoded in the front end and waits in a two-entry queue, so
// new requests are taken while a result waits at the output register.
// The back end handles one request at a time. An allocate walks the free
// list for a first fit and falls back to the bump pointer; a free or
// reallocate first scans the block table, one entry per cycle, until it
// finds the block. Both walks run at one RAM read a cycle. Reset is
// synchronous and needs no clearing pass: only table entries below the
// block count are ever used. A stalled output holds the back end idle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_bump_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] payload_addr,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] result_addr,
  output      logic [1:0]  status,
  output      logic [31:0] copy_len,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Classified request travelling from front end into the queue.
  logic  q_push;
  logic  q_full;
  item_t q_in;

  // Head of the queue as seen by the back end.
  logic  q_pop;
  logic  q_not_empty;
  item_t q_head;

  ffba_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .request_size(request_size),
    .payload_addr(payload_addr),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  ffba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // The back end owns the heap registers because a heap start write also
  // reloads the bump pointer while no block has yet been handed out.
  ffba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_addr(result_addr),
    .status     (status),
    .copy_len   (copy_len)
  );

endmodule

`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ffba_front.sv =====
// ----------------------------------------------------------------------------
// ffba_front
// Accepts requests, decodes the command and rounds the requested size.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_front import ffba_pkg::*; (
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] payload_addr,
  input  wire logic        q_full,
  output      logic        q_push,
  output      item_t       q_item
);

  logic [32:0] sz0;
  logic [32:0] sz;

  always_comb begin
    sz0 = (request_size == 32'd0) ? 33'd1 : {1'b0, request_size};
    sz  = (sz0 + ROUND_ADD) & ROUND_MASK;

    q_item.req     = request_size;
    q_item.payload = payload_addr;
    q_item.hdr     = payload_addr - HDR_BYTES;
    q_item.sz      = sz;
    q_item.need    = {1'b0, sz} + {2'b00, HDR_BYTES};

    // A free of address zero does nothing; a reallocate of zero allocates.
    case (cmd)
      CMD_ALLOC:   q_item.op = OP_ALLOC;
      CMD_FREE:    q_item.op = (payload_addr == 32'd0) ? OP_NOP : OP_FREE;
      CMD_REALLOC: q_item.op = (payload_addr == 32'd0) ? OP_ALLOC : OP_REALLOC;
      default:     q_item.op = OP_NOP;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== rtl/ffba_queue.sv =====
// ----------------------------------------------------------------------------
// ffba_queue
// Two-entry queue of classified requests between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_queue import ffba_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  not_empty,
  output      item_t head
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffba_back.sv =====
// ----------------------------------------------------------------------------
// ffba_back
// Executes requests: block table search, free-list walk, bump and push.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_back import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_not_empty,
  input  wire item_t       q_head,
  output      logic        q_pop,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] result_addr,
  output      logic [1:0]  status,
  output      logic [31:0] copy_len
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam logic [NW-1:0] NONE_IDX = NW'(MAX_BLOCKS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_WALK = 5'b00100,
    S_BUMP = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t        state;
  item_t         it;
  logic [31:0]   heap_end;
  logic [31:0]   bump;
  logic [NW-1:0] free_head;
  logic [NW-1:0] count;
  logic [NW-1:0] scan;
  logic          chk_v;
  logic [AW-1:0] chk_idx;
  logic [NW-1:0] cur;
  logic [NW-1:0] prev;
  logic [NW-1:0] steps;
  logic          pend;
  logic          mv;
  logic [AW-1:0] old_idx;
  logic [31:0]   old_bytes;
  logic [31:0]   res_addr;

  logic [AW-1:0] rd_addr;
  logic [31:0]   base_rd;
  logic [31:0]   bytes_rd;
  logic [NW-1:0] nf_rd;
  logic          isf_rd;

  logic          base_we;
  logic          nf_we;
  logic [AW-1:0] nf_waddr;
  logic [NW-1:0] nf_wdata;
  logic          isf_we;
  logic [AW-1:0] isf_waddr;
  logic          isf_wdata;

  logic          hit;
  logic          fit;
  logic          walk_go;
  logic          walk_cont;
  logic [NW-1:0] steps_inc;
  logic          bump_fail;
  logic [33:0]   bump_sum;

  always_comb begin
    hit       = chk_v && (base_rd == it.hdr);
    fit       = {1'b0, bytes_rd} >= it.sz;
    steps_inc = steps + NW'(1);
    walk_go   = (cur < count) && (steps < NONE_IDX);
    walk_cont = (nf_rd < count) && (steps_inc < NONE_IDX);
    bump_sum  = {2'b00, bump} + it.need;
    bump_fail = (count == NONE_IDX) || (bump_sum > {2'b00, heap_end});

    rd_addr = scan[AW-1:0];
    if (state == S_WALK) begin
      rd_addr = pend ? nf_rd[AW-1:0] : cur[AW-1:0];
    end

    base_we   = 1'b0;
    nf_we     = 1'b0;
    nf_waddr  = count[AW-1:0];
    nf_wdata  = NONE_IDX;
    isf_we    = 1'b0;
    isf_waddr = count[AW-1:0];
    isf_wdata = 1'b0;

    case (state)
      S_FIND: begin
        if (hit && !isf_rd && it.op == OP_FREE) begin
          nf_we     = 1'b1;
          nf_waddr  = chk_idx;
          nf_wdata  = free_head;
          isf_we    = 1'b1;
          isf_waddr = chk_idx;
          isf_wdata = 1'b1;
        end
      end
      S_WALK: begin
        if (pend && fit) begin
          isf_we    = 1'b1;
          isf_waddr = cur[AW-1:0];
          nf_we     = (prev != NONE_IDX);
          nf_waddr  = prev[AW-1:0];
          nf_wdata  = nf_rd;
        end
      end
      S_BUMP: begin
        if (!bump_fail) begin
          base_we = 1'b1;
          nf_we   = 1'b1;
          isf_we  = 1'b1;
        end
      end
      S_PUSH: begin
        nf_we     = 1'b1;
        nf_waddr  = old_idx;
        nf_wdata  = free_head;
        isf_we    = 1'b1;
        isf_waddr = old_idx;
        isf_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_base_ram (
    .clk(clk), .we(base_we), .waddr(count[AW-1:0]), .wdata(bump),
    .raddr(rd_addr), .rdata(base_rd)
  );

  ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_bytes_ram (
    .clk(clk), .we(base_we), .waddr(count[AW-1:0]), .wdata(it.sz[31:0]),
    .raddr(rd_addr), .rdata(bytes_rd)
  );

  ffba_ram #(.WIDTH(NW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk(clk), .we(nf_we), .waddr(nf_waddr), .wdata(nf_wdata),
    .raddr(rd_addr), .rdata(nf_rd)
  );

  ffba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_free_ram (
    .clk(clk), .we(isf_we), .waddr(isf_waddr), .wdata(isf_wdata),
    .raddr(rd_addr), .rdata(isf_rd)
  );

  assign cfg_ready = 1'b1;
  assign q_pop     = (state == S_IDLE) && q_not_empty && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_head  <= NONE_IDX;
      count      <= '0;
      bump       <= HEAP_START_RESET;
      heap_end   <= HEAP_END_RESET;
      chk_v      <= 1'b0;
      pend       <= 1'b0;
      mv         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (q_pop) begin
            it    <= q_head;
            mv    <= 1'b0;
            scan  <= '0;
            chk_v <= 1'b0;
            cur   <= free_head;
            prev  <= NONE_IDX;
            steps <= '0;
            pend  <= 1'b0;
            case (q_head.op)
              OP_ALLOC: state <= S_WALK;
              OP_FREE, OP_REALLOC: state <= S_FIND;
              default: begin
                out_valid   <= 1'b1;
                result_addr <= '0;
                status      <= ST_OK;
                copy_len    <= '0;
              end
            endcase
          end
        end

        S_FIND: begin
          if (hit) begin
            chk_v <= 1'b0;
            if (isf_rd) begin
              out_valid   <= 1'b1;
              result_addr <= '0;
              status      <= ST_UNKNOWN;
              copy_len    <= '0;
              state       <= S_IDLE;
            end else if (it.op == OP_FREE) begin
              free_head   <= {{(NW-AW){1'b0}}, chk_idx};
              out_valid   <= 1'b1;
              result_addr <= '0;
              status      <= ST_OK;
              copy_len    <= '0;
              state       <= S_IDLE;
            end else if (it.req <= bytes_rd) begin
              out_valid   <= 1'b1;
              result_addr <= it.payload;
              status      <= ST_OK;
              copy_len    <= '0;
              state       <= S_IDLE;
            end else begin
              mv        <= 1'b1;
              old_idx   <= chk_idx;
              old_bytes <= bytes_rd;
              state     <= S_WALK;
            end
          end else if (scan < count) begin
            chk_v   <= 1'b1;
            chk_idx <= scan[AW-1:0];
            scan    <= scan + NW'(1);
          end else begin
            chk_v       <= 1'b0;
            out_valid   <= 1'b1;
            result_addr <= '0;
            status      <= ST_UNKNOWN;
            copy_len    <= '0;
            state       <= S_IDLE;
          end
        end

        S_WALK: begin
          if (!pend) begin
            if (walk_go) begin
              pend <= 1'b1;
            end else begin
              state <= S_BUMP;
            end
          end else if (fit) begin
            pend <= 1'b0;
            if (prev == NONE_IDX) begin
              free_head <= nf_rd;
            end
            if (mv) begin
              res_addr <= base_rd + HDR_BYTES;
              state    <= S_PUSH;
            end else begin
              out_valid   <= 1'b1;
              result_addr <= base_rd + HDR_BYTES;
              status      <= ST_OK;
              copy_len    <= '0;
              state       <= S_IDLE;
            end
          end else begin
            prev  <= cur;
            cur   <= nf_rd;
            steps <= steps_inc;
            if (!walk_cont) begin
              pend  <= 1'b0;
              state <= S_BUMP;
            end
          end
        end

        S_BUMP: begin
          if (bump_fail) begin
            out_valid   <= 1'b1;
            result_addr <= '0;
            status      <= ST_NOMEM;
            copy_len    <= '0;
            state       <= S_IDLE;
          end else begin
            count <= count + NW'(1);
            bump  <= bump_sum[31:0];
            if (mv) begin
              res_addr <= bump + HDR_BYTES;
              state    <= S_PUSH;
            end else begin
              out_valid   <= 1'b1;
              result_addr <= bump + HDR_BYTES;
              status      <= ST_OK;
              copy_len    <= '0;
              state       <= S_IDLE;
            end
          end
        end

        S_PUSH: begin
          free_head   <= {{(NW-AW){1'b0}}, old_idx};
          out_valid   <= 1'b1;
          result_addr <= res_addr;
          status      <= ST_OK;
          copy_len    <= old_bytes;
          state       <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase

      // A heap start write only matters while the table is empty, when it
      // reloads the bump pointer; reset restores the default start anyway.
      if (cfg_valid) begin
        if (cfg_index == REG_HEAP_START) begin
          if (count == '0) begin
            bump <= cfg_data;
          end
        end else begin
          heap_end <= cfg_data;
        end
      end
    end
  end

endmodule

`default_nettype wire
